### rtl/core/scr_pkg.sv
// ============================================================================
// scr_pkg: serial command recognizer definitions
// Command table, event codes and byte classes shared by the RTL and checker.
// ============================================================================
package scr_pkg;

    localparam int LINE_CAPACITY = 96;
    localparam int CMD_COUNT     = 6;
    localparam int CMD_MAX_LEN   = 13;
    localparam int HELD_W        = 7;

    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] LOW_PRINTABLE  = 8'h20;
    localparam logic [7:0] HIGH_PRINTABLE = 8'h7E;
    localparam logic [7:0] LOWER_A        = 8'h61;
    localparam logic [7:0] LOWER_Z        = 8'h7A;
    localparam logic [7:0] CASE_OFFSET    = 8'h20;

    localparam logic [HELD_W-1:0] HELD_LIMIT = HELD_W'(LINE_CAPACITY - 1);

    // command indexes, also bit positions in the match flags
    localparam logic [2:0] CMD_PING       = 3'd0;
    localparam logic [2:0] CMD_QUERY      = 3'd1;
    localparam logic [2:0] CMD_STATUS     = 3'd2;
    localparam logic [2:0] CMD_HELP       = 3'd3;
    localparam logic [2:0] CMD_GATE_IN    = 3'd4;
    localparam logic [2:0] CMD_GATE_OUT   = 3'd5;

    // event codes
    localparam logic [3:0] EV_PONG         = 4'd0;
    localparam logic [3:0] EV_STATUS       = 4'd1;
    localparam logic [3:0] EV_HELP         = 4'd2;
    localparam logic [3:0] EV_IN_OPEN      = 4'd3;
    localparam logic [3:0] EV_IN_DENIED    = 4'd4;
    localparam logic [3:0] EV_OUT_OPEN     = 4'd5;
    localparam logic [3:0] EV_OUT_DENIED   = 4'd6;
    localparam logic [3:0] EV_UNKNOWN      = 4'd7;
    localparam logic [3:0] EV_TOO_LONG     = 4'd8;

    localparam logic [CMD_COUNT-1:0] ALL_FLAGS = '1;

    typedef logic [CMD_COUNT-1:0] flags_t;

    function automatic logic [3:0] cmd_len(input logic [2:0] idx);
        logic [3:0] len;
        case (idx)
            CMD_PING:       len = 4'd4;
            CMD_QUERY:      len = 4'd10;
            CMD_STATUS:     len = 4'd6;
            CMD_HELP:       len = 4'd4;
            CMD_GATE_IN:    len = 4'd12;
            CMD_GATE_OUT:   len = 4'd13;
            default:        len = 4'd0;
        endcase
        return len;
    endfunction

    // Character of command idx at line position pos; zero past the end.
    // Text literals are right-justified, so first char sits highest.
    function automatic logic [7:0] cmd_char(input logic [2:0] idx,
                                            input logic [HELD_W-1:0] pos);
        logic [CMD_MAX_LEN*8-1:0] txt;
        logic [3:0]               len;
        logic [3:0]               k;
        logic [7:0]               ch;
        len = cmd_len(idx);
        case (idx)
            CMD_PING:       txt = (CMD_MAX_LEN*8)'("PING");
            CMD_QUERY:      txt = (CMD_MAX_LEN*8)'({"GET_", "STATUS"});
            CMD_STATUS:     txt = (CMD_MAX_LEN*8)'("STATUS");
            CMD_HELP:       txt = (CMD_MAX_LEN*8)'("HELP");
            CMD_GATE_IN:    txt = (CMD_MAX_LEN*8)'({"OPEN_", "GATE_IN"});
            CMD_GATE_OUT:   txt = (CMD_MAX_LEN*8)'({"OPEN_", "GATE_OUT"});
            default:        txt = '0;
        endcase
        k = len - 4'd1 - pos[3:0];
        if (pos < {3'b000, len}) begin
            ch = txt[k*8 +: 8];
        end else begin
            ch = 8'h00;
        end
        return ch;
    endfunction

endpackage

### rtl/core/serial_command_recognizer_top.sv
// ============================================================================
// serial_command_recognizer_top: ASCII command recognizer
// Matches bytes to six fixed commands, one byte a cycle while s_ready is high.
// ============================================================================
// Each event is registered in the result register, or in the skid entry.
// Throughput: one byte per cycle while s_ready is high; the per-command
//   compare, the length update and the match priority all settle between the
//   line state and the result register.
// Reset (aresetn low, synchronous): line empty, all match flags set, result
//   register and skid stage empty.
//
// The line itself is never stored. chars_held_reg counts bytes in the line and
// flags_reg holds one bit per command that is set while the line is still a
// prefix of that command. A command fires the moment its flag is set and the
// count equals its length; the line is then cleared.
//
// Output side: a result register followed by one skid entry. s_ready drops
// only when the skid entry holds a result, so a stalled consumer does not stop
// the next byte from being taken.
module serial_command_recognizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    // byte request channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_entry_allowed,
    input  logic       s_exit_allowed,
    // event channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_event_code
);

    // line state
    logic [scr_pkg::HELD_W-1:0] chars_held_reg, chars_held_next;
    scr_pkg::flags_t            flags_reg, flags_next;

    // output register and skid stage
    logic       m_valid_reg, m_valid_next;
    logic [3:0] m_code_reg, m_code_next;
    logic       skid_valid_reg, skid_valid_next;
    logic [3:0] skid_code_reg, skid_code_next;

    // per-byte decode
    logic       accept;
    logic       ev_valid;
    logic [3:0] ev_code;

    assign accept = s_valid && s_ready;

    always_comb begin
        logic [7:0]                 ch;
        logic [scr_pkg::HELD_W-1:0] held_inc;
        scr_pkg::flags_t            match;
        logic                       hit;
        logic [2:0]                 hit_idx;

        chars_held_next = chars_held_reg;
        flags_next      = flags_reg;
        ev_valid        = 1'b0;
        ev_code         = scr_pkg::EV_UNKNOWN;
        hit             = 1'b0;
        hit_idx         = scr_pkg::CMD_PING;
        held_inc        = chars_held_reg + 1'b1;

        // fold lower case
        ch = s_rx_byte;
        if (s_rx_byte inside {[scr_pkg::LOWER_A:scr_pkg::LOWER_Z]}) begin
            ch = s_rx_byte - scr_pkg::CASE_OFFSET;
        end

        // prefix check of every command at the current position
        for (int i = 0; i < scr_pkg::CMD_COUNT; i++) begin
            match[i] = flags_reg[i]
                && (chars_held_reg < {3'b000, scr_pkg::cmd_len(3'(i))})
                && (scr_pkg::cmd_char(3'(i), chars_held_reg) == ch);
        end

        // lowest index wins; exact-length matches never overlap anyway
        for (int i = scr_pkg::CMD_COUNT - 1; i >= 0; i--) begin
            if (match[i] && ({3'b000, scr_pkg::cmd_len(3'(i))} == held_inc)) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end

        if (accept) begin
            if (s_rx_byte inside {scr_pkg::CHAR_CR, scr_pkg::CHAR_LF}) begin
                // line ending: a non-empty line here is never a command
                if (chars_held_reg != '0) begin
                    ev_valid        = 1'b1;
                    ev_code         = scr_pkg::EV_UNKNOWN;
                    chars_held_next = '0;
                    flags_next      = scr_pkg::ALL_FLAGS;
                end
            end else if (s_rx_byte inside
                         {[scr_pkg::LOW_PRINTABLE:scr_pkg::HIGH_PRINTABLE]}) begin
                if (chars_held_reg >= scr_pkg::HELD_LIMIT) begin
                    ev_valid        = 1'b1;
                    ev_code         = scr_pkg::EV_TOO_LONG;
                    chars_held_next = '0;
                    flags_next      = scr_pkg::ALL_FLAGS;
                end else if (hit) begin
                    ev_valid        = 1'b1;
                    chars_held_next = '0;
                    flags_next      = scr_pkg::ALL_FLAGS;
                    case (hit_idx)
                        scr_pkg::CMD_PING:       ev_code = scr_pkg::EV_PONG;
                        scr_pkg::CMD_QUERY:      ev_code = scr_pkg::EV_STATUS;
                        scr_pkg::CMD_STATUS:     ev_code = scr_pkg::EV_STATUS;
                        scr_pkg::CMD_HELP:       ev_code = scr_pkg::EV_HELP;
                        scr_pkg::CMD_GATE_IN: begin
                            ev_code = s_entry_allowed ? scr_pkg::EV_IN_OPEN
                                                      : scr_pkg::EV_IN_DENIED;
                        end
                        scr_pkg::CMD_GATE_OUT: begin
                            ev_code = s_exit_allowed ? scr_pkg::EV_OUT_OPEN
                                                     : scr_pkg::EV_OUT_DENIED;
                        end
                        default:                 ev_code = scr_pkg::EV_UNKNOWN;
                    endcase
                end else begin
                    chars_held_next = held_inc;
                    flags_next      = match;
                end
            end
            // other control and high bytes are dropped silently
        end
    end

    // output register plus skid entry
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_code_next     = m_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                // no new request can arrive while the skid entry is full
                m_valid_next    = 1'b1;
                m_code_next     = skid_code_reg;
                skid_valid_next = 1'b0;
            end else begin
                m_valid_next = ev_valid;
                m_code_next  = ev_code;
            end
        end else if (ev_valid) begin
            skid_valid_next = 1'b1;
            skid_code_next  = ev_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_held_reg <= '0;
            flags_reg      <= scr_pkg::ALL_FLAGS;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            chars_held_reg <= chars_held_next;
            flags_reg      <= flags_next;
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_code_reg    <= m_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign s_ready      = !skid_valid_reg;
    assign m_valid      = m_valid_reg;
    assign m_event_code = m_code_reg;

endmodule

### rtl/core/scr_checker.sv
// ============================================================================
// scr_checker: port-level checks for the command recognizer
// Watches the top-level ports only; attached by bind.
// ============================================================================
module scr_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [7:0] s_rx_byte,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_event_code
);

    // stalled event holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_code))
        else $error("event changed while stalled");

    // only defined codes leave the block
    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_event_code <= scr_pkg::EV_TOO_LONG)
        else $error("undefined event code");

    // reset empties the output side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("event present after reset");

    // back-pressure on bytes only while a full result is waiting
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("request stalled with empty output");

    // a dropped NUL byte yields no event
    a_nul_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_rx_byte == 8'h00) && (!m_valid || m_ready)
        |=> !m_valid)
        else $error("event from dropped byte");

endmodule

bind serial_command_recognizer_top scr_checker u_scr_checker (.*);
